### rtl/jdef_pkg.sv
package jdef_pkg;

  localparam int unsigned DEPTH_WIDTH_DEF  = 16;
  localparam int unsigned OFFSET_WIDTH_DEF = 32;
  localparam int unsigned END_OFFSET_WIDTH = 32;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;

  typedef struct packed {
    logic [END_OFFSET_WIDTH-1:0] end_offset;
    logic                        is_array;
    logic                        depth_overflow;
  } result_t;

endpackage

### rtl/jdef_in_reg.sv
module jdef_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       room_i,
  output logic       advance_o,
  output logic [7:0] byte_o
);
  import jdef_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       accept;

  assign in_stall_o = valid_q && !room_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign advance_o  = valid_q && room_i;
  assign byte_o     = byte_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= data_byte_i;
    end
  end

endmodule

### rtl/jdef_scan.sv
module jdef_scan #(
  parameter int unsigned DEPTH_WIDTH  = jdef_pkg::DEPTH_WIDTH_DEF,
  parameter int unsigned OFFSET_WIDTH = jdef_pkg::OFFSET_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  logic [7:0]        byte_i,
  output logic              res_valid_o,
  output jdef_pkg::result_t res_o
);
  import jdef_pkg::*;

  logic                    searching_q, searching_d;
  logic                    array_kind_q, array_kind_d;
  logic [DEPTH_WIDTH-1:0]  depth_q, depth_d;
  logic                    quoted_q, quoted_d;
  logic                    skip_q, skip_d;
  logic [OFFSET_WIDTH-1:0] offset_q, offset_d;
  logic                    ovf_q, ovf_d;

  logic [7:0]              opener, closer;
  logic [63:0]             offset_ext;

  assign opener     = array_kind_q ? CH_LBRACK : CH_LBRACE;
  assign closer     = array_kind_q ? CH_RBRACK : CH_RBRACE;
  assign offset_ext = 64'(offset_q);

  always_comb begin
    searching_d  = searching_q;
    array_kind_d = array_kind_q;
    depth_d      = depth_q;
    quoted_d     = quoted_q;
    skip_d       = skip_q;
    offset_d     = (offset_q == '1) ? offset_q : offset_q + 1'b1;
    ovf_d        = ovf_q;
    res_valid_o  = 1'b0;

    res_o.end_offset     = (|offset_ext[63:END_OFFSET_WIDTH]) ? '1
                                                              : offset_ext[END_OFFSET_WIDTH-1:0];
    res_o.is_array       = array_kind_q;
    res_o.depth_overflow = ovf_q;

    if (searching_q) begin
      if (byte_i == CH_LBRACE || byte_i == CH_LBRACK) begin
        searching_d  = 1'b0;
        array_kind_d = (byte_i == CH_LBRACK);
        depth_d      = DEPTH_WIDTH'(1);
        quoted_d     = 1'b0;
        skip_d       = 1'b0;
        ovf_d        = 1'b0;
      end
    end else if (skip_q) begin
      skip_d = 1'b0;
    end else if (byte_i == CH_BSLASH) begin
      skip_d = 1'b1;
    end else if (byte_i == CH_QUOTE) begin
      quoted_d = !quoted_q;
    end else if (!quoted_q) begin
      if (byte_i == opener) begin
        if (depth_q == '1) begin
          ovf_d = 1'b1;
        end else begin
          depth_d = depth_q + 1'b1;
        end
      end else if (byte_i == closer) begin
        if (depth_q != '0) begin
          depth_d = depth_q - 1'b1;
        end
        if (depth_q <= DEPTH_WIDTH'(1)) begin
          res_valid_o = 1'b1;
          searching_d = 1'b1;
          quoted_d    = 1'b0;
          skip_d      = 1'b0;
          ovf_d       = 1'b0;
          offset_d    = '0;
        end
      end
    end

    if (!advance_i) begin
      res_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      searching_q  <= 1'b1;
      array_kind_q <= 1'b0;
      depth_q      <= '0;
      quoted_q     <= 1'b0;
      skip_q       <= 1'b0;
      offset_q     <= '0;
      ovf_q        <= 1'b0;
    end else if (advance_i) begin
      searching_q  <= searching_d;
      array_kind_q <= array_kind_d;
      depth_q      <= depth_d;
      quoted_q     <= quoted_d;
      skip_q       <= skip_d;
      offset_q     <= offset_d;
      ovf_q        <= ovf_d;
    end
  end

endmodule

### rtl/jdef_out_reg.sv
module jdef_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  logic              res_valid_i,
  input  jdef_pkg::result_t res_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output jdef_pkg::result_t res_o
);
  import jdef_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;
  logic    load;

  assign room_o      = !valid_q || !out_stall_i;
  assign load        = advance_i && res_valid_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

endmodule

### rtl/json_document_end_framer.sv
// path: an accepted byte goes to the input register, and a result it completes is loaded into the result register
// throughput: one byte per cycle, limited only by the output stall
// the input register holds one byte while the result register is full and stalled
// reset: asynchronous active-low rst_ni empties both registers and restarts the
// search for an opener with the offset at zero
module json_document_end_framer #(
  parameter int unsigned DEPTH_WIDTH  = jdef_pkg::DEPTH_WIDTH_DEF,
  parameter int unsigned OFFSET_WIDTH = jdef_pkg::OFFSET_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [7:0]                            data_byte_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [jdef_pkg::END_OFFSET_WIDTH-1:0] end_offset_o,
  output logic                                  is_array_o,
  output logic                                  depth_overflow_o
);
  import jdef_pkg::*;

  logic       room;
  logic       advance;
  logic [7:0] byte_s1;
  logic       res_valid;
  result_t    res_d;
  result_t    res_q;

  jdef_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .room_i      (room),
    .advance_o   (advance),
    .byte_o      (byte_s1)
  );

  jdef_scan #(
    .DEPTH_WIDTH  (DEPTH_WIDTH),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .byte_i      (byte_s1),
    .res_valid_o (res_valid),
    .res_o       (res_d)
  );

  jdef_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .res_valid_i (res_valid),
    .res_i       (res_d),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_q)
  );

  assign end_offset_o     = res_q.end_offset;
  assign is_array_o       = res_q.is_array;
  assign depth_overflow_o = res_q.depth_overflow;

endmodule

### rtl/jdef_checker.sv
module jdef_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic [7:0]                            data_byte_i,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic [jdef_pkg::END_OFFSET_WIDTH-1:0] end_offset_o,
  input logic                                  is_array_o,
  input logic                                  depth_overflow_o
);
  import jdef_pkg::*;

  // input only backs up behind a full, stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while result register free");

  // a fresh result needs an accepted input word behind it
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result appeared without an accepted word");

  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      ($stable(end_offset_o) && $stable(is_array_o) && $stable(depth_overflow_o)))
    else $error("stalled result changed");

  // a stalled input word stays offered unchanged
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(data_byte_i)))
    else $error("stalled input word changed");

endmodule

bind json_document_end_framer jdef_checker u_jdef_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .data_byte_i      (data_byte_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .end_offset_o     (end_offset_o),
  .is_array_o       (is_array_o),
  .depth_overflow_o (depth_overflow_o)
);
